FILE: rtl/assert_macros.svh
// Assertion macros shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SITD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SITD_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define SITD_ASSERT(label, clk, rst, prop, msg)
`define SITD_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

FILE: rtl/sitd_pkg.sv
// Types and constants of the seven-in-six text decoder.
`default_nettype none
package sitd_pkg;

   localparam int unsigned CHAR_W     = 8;
   localparam int unsigned DATA_W     = 7;
   localparam int unsigned STATUS_W   = 3;
   localparam int unsigned LEN_W      = 13;
   localparam int unsigned RSUM_W     = 20;
   localparam int unsigned SSUM_W     = 21;

   localparam int unsigned MAX_LENGTH_DEFAULT  = 4096;
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;
   localparam logic [LEN_W-1:0] EXPECTED_RESET = LEN_W'(155);

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_LEN   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_LEN_MISM  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_SYM   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NO_SEP    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_SUM_MISM  = 3'd5;
   localparam logic [STATUS_W-1:0] ST_SHORT     = 3'd6;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              record_end;
   } req_type;

   typedef struct packed {
      logic                kind;
      logic [DATA_W-1:0]   data_byte;
      logic [STATUS_W-1:0] status;
      logic                run_last;
   } rsp_type;

   // work left for the back end by one character
   typedef struct packed {
      logic                has_byte;
      logic [DATA_W-1:0]   data_byte;
      logic                has_status;
      logic [STATUS_W-1:0] status;
   } task_type;

endpackage
`default_nettype wire

FILE: rtl/seven_in_six_text_decoder.sv
// Each character's work goes into the work queue, then into the output register.
// Throughput: one character per cycle while the queue is not full; one result beat
// per cycle unless stalled, so a byte-and-status pair is absorbed by the work queue.
// The output register is the single beat-per-cycle point of the design.
// Reset: synchronous; record state cleared, expected length set to 155, no clear pass.
`default_nettype none
module seven_in_six_text_decoder #(
   parameter int unsigned MAX_LENGTH  = sitd_pkg::MAX_LENGTH_DEFAULT,
   parameter int unsigned QUEUE_DEPTH = sitd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_write_en,
   input  wire logic [sitd_pkg::LEN_W-1:0]  csr_write_data,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire sitd_pkg::req_type           req_payload,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output sitd_pkg::rsp_type                rsp_payload
);

   logic               accept;
   logic               push;
   logic               pop;
   logic               q_full;
   logic               q_empty;
   sitd_pkg::task_type push_task;
   sitd_pkg::task_type pop_task;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   sitd_front #(
      .MAX_LENGTH (MAX_LENGTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .accept         (accept),
      .req            (req_payload),
      .push           (push),
      .push_task      (push_task)
   );

   sitd_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_task),
      .pop       (pop),
      .pop_data  (pop_task),
      .full      (q_full),
      .empty     (q_empty)
   );

   sitd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .task_data   (pop_task),
      .task_empty  (q_empty),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

FILE: rtl/sitd_front.sv
// Front end: parses characters, repacks symbols, checks fields, queues output work.
`default_nettype none
module sitd_front #(
   parameter int unsigned MAX_LENGTH = sitd_pkg::MAX_LENGTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write_en,
   input  wire logic [sitd_pkg::LEN_W-1:0]    csr_write_data,
   input  wire logic                          accept,
   input  wire sitd_pkg::req_type             req,
   output logic                               push,
   output sitd_pkg::task_type                 push_task
);

   typedef enum logic [2:0] {
      PH_LEN,
      PH_DATA,
      PH_SEP,
      PH_SUM,
      PH_DRAIN
   } phase_type;

   localparam logic [sitd_pkg::CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [sitd_pkg::LEN_W-1:0]  LEN_CAP    = '1;
   localparam logic [sitd_pkg::SSUM_W-1:0] SSUM_CAP   = '1;
   localparam int unsigned LMUL_W = sitd_pkg::LEN_W + 4;
   localparam int unsigned SMUL_W = sitd_pkg::SSUM_W + 4;

   // 64 means not in the alphabet
   function automatic logic [6:0] symbol_value(input logic [7:0] c);
      logic [6:0] v;
      v = 7'd64;
      if (c >= 8'h41 && c <= 8'h5A)      v = 7'(c - 8'h41);
      else if (c >= 8'h61 && c <= 8'h7A) v = 7'(c - 8'h61 + 8'd26);
      else if (c >= 8'h30 && c <= 8'h39) v = 7'(c - 8'h30 + 8'd52);
      else if (c == 8'h2B)               v = 7'd62;
      else if (c == 8'h2F)               v = 7'd63;
      return v;
   endfunction

   logic [sitd_pkg::LEN_W-1:0]    expected_ff;
   phase_type                     phase_ff, phase_in;
   logic [sitd_pkg::LEN_W-1:0]    len_acc_ff, len_acc_in;
   logic [12:0]                   bit_reg_ff, bit_reg_in;
   logic [2:0]                    bits_above_ff, bits_above_in;
   logic [sitd_pkg::LEN_W-1:0]    bytes_done_ff, bytes_done_in;
   logic [sitd_pkg::RSUM_W-1:0]   run_sum_ff, run_sum_in;
   logic [sitd_pkg::SSUM_W-1:0]   stated_ff, stated_in;
   logic                          digit_seen_ff, digit_seen_in;

   logic                          is_digit;
   logic [3:0]                    digit_val;
   logic [LMUL_W-1:0]             len_next;
   logic [SMUL_W-1:0]             sum_next;
   logic [6:0]                    sym;
   logic [12:0]                   shifted;
   logic [3:0]                    bits_sum;
   logic [3:0]                    bits_left;
   logic [sitd_pkg::LEN_W-1:0]    bytes_inc;
   logic                          len_bad;
   sitd_pkg::task_type            task_w;

   assign is_digit  = (req.char_code >= 8'h30) && (req.char_code <= 8'h39);
   assign digit_val = req.char_code[3:0];
   assign len_next  = LMUL_W'(len_acc_ff) * LMUL_W'(10) + LMUL_W'(digit_val);
   assign sum_next  = SMUL_W'(stated_ff) * SMUL_W'(10) + SMUL_W'(digit_val);
   assign sym       = symbol_value(req.char_code);
   assign shifted   = {bit_reg_ff[6:0], sym[5:0]};
   assign bits_sum  = 4'(bits_above_ff) + 4'd6;
   assign bits_left = bits_sum - 4'd7;
   assign bytes_inc = bytes_done_ff + sitd_pkg::LEN_W'(1);
   assign len_bad   = (len_acc_ff != expected_ff) ||
                      (32'(expected_ff) > 32'(MAX_LENGTH));

   always_comb begin
      phase_in      = phase_ff;
      len_acc_in    = len_acc_ff;
      bit_reg_in    = bit_reg_ff;
      bits_above_in = bits_above_ff;
      bytes_done_in = bytes_done_ff;
      run_sum_in    = run_sum_ff;
      stated_in     = stated_ff;
      digit_seen_in = digit_seen_ff;
      task_w        = '0;

      unique case (phase_ff)
         PH_LEN: begin
            if (is_digit) begin
               len_acc_in    = (len_next > LMUL_W'(LEN_CAP)) ? LEN_CAP
                                                             : len_next[sitd_pkg::LEN_W-1:0];
               digit_seen_in = 1'b1;
            end else if (req.char_code == CHAR_SPACE && digit_seen_ff) begin
               if (len_bad) begin
                  phase_in      = PH_DRAIN;
                  bits_above_in = sitd_pkg::ST_LEN_MISM;
               end else begin
                  digit_seen_in = 1'b0;
                  phase_in      = (expected_ff == '0) ? PH_SEP : PH_DATA;
               end
            end else begin
               phase_in      = PH_DRAIN;
               bits_above_in = sitd_pkg::ST_BAD_LEN;
            end
         end
         PH_DATA: begin
            if (sym[6]) begin
               phase_in      = PH_DRAIN;
               bits_above_in = sitd_pkg::ST_BAD_SYM;
            end else if (bits_sum >= 4'd7) begin
               task_w.has_byte  = 1'b1;
               task_w.data_byte = 7'(shifted >> bits_left);
               bits_above_in    = bits_left[2:0];
               bit_reg_in       = shifted & ((13'd1 << bits_left) - 13'd1);
               run_sum_in       = run_sum_ff + sitd_pkg::RSUM_W'(task_w.data_byte);
               bytes_done_in    = bytes_inc;
               if (bytes_inc >= expected_ff) begin
                  phase_in      = PH_SEP;
                  bit_reg_in    = '0;
                  bits_above_in = '0;
               end
            end else begin
               bit_reg_in    = shifted;
               bits_above_in = bits_sum[2:0];
            end
         end
         PH_SEP: begin
            if (req.char_code == CHAR_SPACE) begin
               phase_in      = PH_SUM;
               digit_seen_in = 1'b0;
            end else begin
               phase_in      = PH_DRAIN;
               bits_above_in = sitd_pkg::ST_NO_SEP;
            end
         end
         PH_SUM: begin
            if (is_digit) begin
               stated_in     = (sum_next > SMUL_W'(SSUM_CAP)) ? SSUM_CAP
                                                             : sum_next[sitd_pkg::SSUM_W-1:0];
               digit_seen_in = 1'b1;
            end else begin
               phase_in      = PH_DRAIN;
               bits_above_in = sitd_pkg::ST_SUM_MISM;
            end
         end
         default: ;
      endcase

      if (req.record_end) begin
         task_w.has_status = 1'b1;
         if (phase_in == PH_DRAIN)
            task_w.status = bits_above_in;
         else if (phase_in == PH_SUM && digit_seen_in)
            task_w.status = (sitd_pkg::RSUM_W'(stated_in) == run_sum_in &&
                             stated_in[sitd_pkg::SSUM_W-1] == 1'b0)
                            ? sitd_pkg::ST_OK : sitd_pkg::ST_SUM_MISM;
         else
            task_w.status = sitd_pkg::ST_SHORT;
         // record closes: back to the starting state
         phase_in      = PH_LEN;
         len_acc_in    = '0;
         bit_reg_in    = '0;
         bits_above_in = '0;
         bytes_done_in = '0;
         run_sum_in    = '0;
         stated_in     = '0;
         digit_seen_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff   <= sitd_pkg::EXPECTED_RESET;
         phase_ff      <= PH_LEN;
         len_acc_ff    <= '0;
         bit_reg_ff    <= '0;
         bits_above_ff <= '0;
         bytes_done_ff <= '0;
         run_sum_ff    <= '0;
         stated_ff     <= '0;
         digit_seen_ff <= 1'b0;
      end else begin
         if (csr_write_en)
            expected_ff <= csr_write_data;
         if (accept) begin
            phase_ff      <= phase_in;
            len_acc_ff    <= len_acc_in;
            bit_reg_ff    <= bit_reg_in;
            bits_above_ff <= bits_above_in;
            bytes_done_ff <= bytes_done_in;
            run_sum_ff    <= run_sum_in;
            stated_ff     <= stated_in;
            digit_seen_ff <= digit_seen_in;
         end
      end
   end

   assign push      = accept && (task_w.has_byte || task_w.has_status);
   assign push_task = task_w;

endmodule
`default_nettype wire

FILE: rtl/sitd_fifo.sv
// Short work queue between front end and back end.
`default_nettype none
`include "assert_macros.svh"
module sitd_fifo #(
   parameter int unsigned DEPTH = sitd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire sitd_pkg::task_type  push_data,
   input  wire logic                pop,
   output sitd_pkg::task_type       pop_data,
   output logic                     full,
   output logic                     empty
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   sitd_pkg::task_type mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push)
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (pop)
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      if (push && !pop)
         count_in = count_ff + CNT_W'(1);
      else if (pop && !push)
         count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         mem_ff[wr_ptr_ff] <= push_data;
   end

   assign pop_data = mem_ff[rd_ptr_ff];
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);

   `SITD_ASSERT_NEVER(a_no_overflow, clock, reset, push && full, "push into full queue")
   `SITD_ASSERT_NEVER(a_no_underflow, clock, reset, pop && empty, "pop from empty queue")
   `SITD_ASSERT(a_count_up, clock, reset, push && !pop |=> count_ff == $past(count_ff) + CNT_W'(1), "queue count did not advance")

endmodule
`default_nettype wire

FILE: rtl/sitd_back.sv
// Back end: turns queued work into result beats through an output register.
`default_nettype none
`include "assert_macros.svh"
module sitd_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire sitd_pkg::task_type  task_data,
   input  wire logic                task_empty,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output sitd_pkg::rsp_type        rsp_payload
);

   logic                    rsp_valid_ff, rsp_valid_in;
   sitd_pkg::rsp_type       rsp_ff, rsp_in;
   logic                    pending_ff, pending_in;
   logic [sitd_pkg::STATUS_W-1:0] pend_status_ff, pend_status_in;
   logic                    load_ok;

   // output register free this cycle
   assign load_ok = !rsp_valid_ff || !rsp_stall;
   assign pop     = load_ok && !pending_ff && !task_empty;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_in         = rsp_ff;
      pending_in     = pending_ff;
      pend_status_in = pend_status_ff;
      if (load_ok) begin
         rsp_valid_in = 1'b0;
         if (pending_ff) begin
            // second beat of a character that finished a byte and the record
            rsp_valid_in       = 1'b1;
            rsp_in.kind        = sitd_pkg::KIND_STATUS;
            rsp_in.data_byte   = '0;
            rsp_in.status      = pend_status_ff;
            rsp_in.run_last    = 1'b1;
            pending_in         = 1'b0;
         end else if (!task_empty) begin
            rsp_valid_in = 1'b1;
            if (task_data.has_byte) begin
               rsp_in.kind      = sitd_pkg::KIND_DATA;
               rsp_in.data_byte = task_data.data_byte;
               rsp_in.status    = sitd_pkg::ST_OK;
               rsp_in.run_last  = !task_data.has_status;
               pending_in       = task_data.has_status;
               pend_status_in   = task_data.status;
            end else begin
               rsp_in.kind      = sitd_pkg::KIND_STATUS;
               rsp_in.data_byte = '0;
               rsp_in.status    = task_data.status;
               rsp_in.run_last  = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pending_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pending_ff   <= pending_in;
      end
      rsp_ff         <= rsp_in;
      pend_status_ff <= pend_status_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `SITD_ASSERT(a_pending_behind_byte, clock, reset, pending_ff |-> rsp_valid_ff && rsp_ff.kind == sitd_pkg::KIND_DATA && !rsp_ff.run_last, "pending status without byte beat")
   `SITD_ASSERT(a_no_pop_pending, clock, reset, pop |-> !pending_ff, "queue popped with status pending")
   `SITD_ASSERT(a_status_last, clock, reset, rsp_valid_ff && rsp_ff.kind == sitd_pkg::KIND_STATUS |-> rsp_ff.run_last, "status beat not marked last")

endmodule
`default_nettype wire
